// ===== src/pawg_pkg.sv =====
package pawg_pkg;

    // Widths of the sample path and configuration
    localparam int SAMPLE_W      = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int PHASE_WIDTH_DEFAULT = 16;

    // Sample queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    // Accumulator width of the sine polynomial
    localparam int ACC_W         = 33;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd2;

    // Reset values of the registers
    localparam logic [SAMPLE_W-1:0] PHASE_STEP_RESET = 16'd137;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 16'd16384;

    // Q15 limits and fold points
    localparam logic signed [SAMPLE_W-1:0] Q15_MAX   = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] Q15_MIN   = -16'sd32768;
    localparam logic signed [SAMPLE_W:0]   FOLD_HI   = 17'sd16384;
    localparam logic signed [SAMPLE_W:0]   FOLD_LO   = -17'sd16384;
    localparam logic [SAMPLE_W-1:0]        TRI_BIAS  = 16'h8001;
    localparam logic signed [ACC_W-1:0]    ROUND_ADD = 33'sd2048;

    // Taylor coefficients, Q3.12
    localparam logic signed [SAMPLE_W-1:0] COEF_A1 = 16'sd12868;
    localparam logic signed [SAMPLE_W-1:0] COEF_A3 = -16'sd21167;
    localparam logic signed [SAMPLE_W-1:0] COEF_A5 = 16'sd10445;
    localparam logic signed [SAMPLE_W-1:0] COEF_A7 = -16'sd2455;

    typedef enum logic [1:0] {
        MODE_SAWTOOTH = 2'd0,
        MODE_SQUARE   = 2'd1,
        MODE_TRIANGLE = 2'd2,
        MODE_SINE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } back_state_t;

    // One multiply per step: powers first, then polynomial terms
    typedef enum logic [2:0] {
        STEP_X2 = 3'd0,
        STEP_X3 = 3'd1,
        STEP_X5 = 3'd2,
        STEP_X7 = 3'd3,
        STEP_T1 = 3'd4,
        STEP_T3 = 3'd5,
        STEP_T5 = 3'd6,
        STEP_T7 = 3'd7
    } step_t;

    // Word carried through the queue: phase sample and block marker
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] phase;
        logic                       last;
    } item_t;

    // Queue handshake between front and queue
    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

    // Saturating Q15 multiply result: floor(2*prod / 65536)
    function automatic logic signed [SAMPLE_W-1:0] qmul_sat(
        input logic signed [2*SAMPLE_W-1:0] prod
    );
        logic signed [2*SAMPLE_W-1:0] sh;
        sh = prod >>> 15;
        if (sh > 32'sd32767)
            return Q15_MAX;
        else if (sh < -32'sd32768)
            return Q15_MIN;
        else
            return sh[SAMPLE_W-1:0];
    endfunction

    // Round, scale Q3.12 back to Q15 and saturate
    function automatic logic signed [SAMPLE_W-1:0] poly_out(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] sh;
        sh = (acc + ROUND_ADD) >>> 12;
        if (sh > 33'sd32767)
            return Q15_MAX;
        else if (sh < -33'sd32768)
            return Q15_MIN;
        else
            return sh[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== src/phase_accumulator_waveform_generator.sv =====
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_last_of_block
// m_        m_valid / m_ready    m_sample, m_last_out
// cfg_      cfg_wr_en            cfg_index, cfg_wr_data
//
// Sawtooth, square and triangle words pass the queue, the IDLE and DONE states and the output register;
// sine words also run the eight ST_MUL steps of the one shared 16x16 multiplier.
// Ticks are taken at one per clock until the two-word queue fills; the back end
// takes a new word from the queue only once the last one is loaded for output.
// Synchronous active-low reset clears the phase, the queue and the output valid flag.
// A stalled m_ready holds the output word; the back end then waits in place.
module phase_accumulator_waveform_generator #(
    parameter int PHASE_WIDTH = pawg_pkg::PHASE_WIDTH_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_last_of_block,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pawg_pkg::SAMPLE_W-1:0]    m_sample,
    output logic                                    m_last_out,
    input  logic                                    cfg_wr_en,
    input  logic [pawg_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [pawg_pkg::CFG_DATA_W-1:0]         cfg_wr_data
);

    pawg_pkg::mode_t                        mode_reg;
    logic signed [pawg_pkg::SAMPLE_W-1:0]   phase_step_reg;
    logic signed [pawg_pkg::SAMPLE_W-1:0]   threshold_reg;

    pawg_pkg::push_t                        q_push;
    pawg_pkg::item_t                        q_item;
    logic                                   q_full;
    logic                                   q_valid;
    logic                                   q_pop;

    // Write the configuration registers; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= pawg_pkg::MODE_SAWTOOTH;
            phase_step_reg <= pawg_pkg::PHASE_STEP_RESET;
            threshold_reg  <= pawg_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pawg_pkg::REG_MODE:
                    mode_reg <= pawg_pkg::mode_t'(cfg_wr_data[1:0]);
                pawg_pkg::REG_PHASE_STEP:
                    phase_step_reg <= cfg_wr_data;
                pawg_pkg::REG_THRESHOLD:
                    threshold_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    pawg_front #(
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_last_of_block (s_last_of_block),
        .phase_step      (phase_step_reg),
        .q_full          (q_full),
        .q_push          (q_push)
    );

    pawg_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    pawg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .mode       (mode_reg),
        .threshold  (threshold_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sample   (m_sample),
        .m_last_out (m_last_out)
    );

endmodule

// ===== src/pawg_front.sv =====
module pawg_front #(
    parameter int PHASE_WIDTH = pawg_pkg::PHASE_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_last_of_block,
    input  logic signed [pawg_pkg::SAMPLE_W-1:0]  phase_step,
    input  logic                                  q_full,
    output pawg_pkg::push_t                       q_push
);

    logic [PHASE_WIDTH-1:0]       phase_reg;
    logic [PHASE_WIDTH-1:0]       phase_next;
    logic [PHASE_WIDTH-1:0]       step_ext;
    logic [pawg_pkg::SAMPLE_W-1:0] top_phase;
    logic                         accept;

    // Sign-extend or truncate the step to the accumulator width
    assign step_ext = PHASE_WIDTH'(phase_step);

    // Take the top 16 bits of the phase, zero fill when narrower
    generate
        if (PHASE_WIDTH >= pawg_pkg::SAMPLE_W) begin : g_wide
            assign top_phase = phase_reg[PHASE_WIDTH-1 -: pawg_pkg::SAMPLE_W];
        end else begin : g_narrow
            assign top_phase = {phase_reg, {(pawg_pkg::SAMPLE_W-PHASE_WIDTH){1'b0}}};
        end
    endgenerate

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Advance the phase on every accepted tick
    assign phase_next = phase_reg + step_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    // Hand the current phase to the queue
    always_comb begin
        q_push.push       = accept;
        q_push.item.phase = top_phase;
        q_push.item.last  = s_last_of_block;
    end

endmodule

// ===== src/pawg_queue.sv =====
module pawg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  pawg_pkg::push_t   q_push,
    output logic              q_full,
    output logic              q_valid,
    output pawg_pkg::item_t   q_item,
    input  logic              q_pop
);

    pawg_pkg::item_t                   mem_reg [pawg_pkg::QUEUE_DEPTH];
    logic [pawg_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [pawg_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [pawg_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [pawg_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_full  = (count_reg == pawg_pkg::QUEUE_CNT_W'(pawg_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Track pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= q_push.item;
    end

endmodule

// ===== src/pawg_back.sv =====
module pawg_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_valid,
    input  pawg_pkg::item_t                       q_item,
    output logic                                  q_pop,
    input  pawg_pkg::mode_t                       mode,
    input  logic signed [pawg_pkg::SAMPLE_W-1:0]  threshold,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pawg_pkg::SAMPLE_W-1:0]  m_sample,
    output logic                                  m_last_out
);

    localparam int W = pawg_pkg::SAMPLE_W;

    pawg_pkg::back_state_t    state_reg;
    pawg_pkg::back_state_t    state_next;
    pawg_pkg::step_t          step_reg;

    logic signed [W-1:0]      p_reg;
    logic                     last_reg;
    logic signed [W-1:0]      x_reg;
    logic signed [W-1:0]      x2_reg;
    logic signed [W-1:0]      x3_reg;
    logic signed [W-1:0]      x5_reg;
    logic signed [W-1:0]      x7_reg;
    logic signed [pawg_pkg::ACC_W-1:0] acc_reg;

    logic                     out_valid_reg;
    logic signed [W-1:0]      out_sample_reg;
    logic                     out_last_reg;

    logic                     out_free;
    logic                     load_out;
    logic signed [W-1:0]      mul_a;
    logic signed [W-1:0]      mul_b;
    logic signed [2*W-1:0]    prod;
    logic signed [W-1:0]      qprod;
    logic signed [W:0]        p_ext;
    logic signed [W:0]        fold;
    logic [W-1:0]             abs_p;
    logic signed [W-1:0]      result;

    assign out_free = !out_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pawg_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (mode == pawg_pkg::MODE_SINE)
                        state_next = pawg_pkg::ST_MUL;
                    else
                        state_next = pawg_pkg::ST_DONE;
                end
            end
            pawg_pkg::ST_MUL: begin
                if (step_reg == pawg_pkg::STEP_T7)
                    state_next = pawg_pkg::ST_DONE;
            end
            pawg_pkg::ST_DONE: begin
                if (out_free)
                    state_next = pawg_pkg::ST_IDLE;
            end
            default: state_next = pawg_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            pawg_pkg::ST_IDLE: q_pop    = q_valid;
            pawg_pkg::ST_MUL:  ;
            pawg_pkg::ST_DONE: load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pawg_pkg::ST_IDLE;
            step_reg  <= pawg_pkg::STEP_X2;
        end else begin
            state_reg <= state_next;
            if (state_reg == pawg_pkg::ST_MUL)
                step_reg <= pawg_pkg::step_t'(step_reg + 3'd1);
            else
                step_reg <= pawg_pkg::STEP_X2;
        end
    end

    // Fold the phase into the quarter wave about zero
    assign p_ext = {q_item.phase[W-1], q_item.phase};
    always_comb begin
        if (p_ext > pawg_pkg::FOLD_HI)
            fold = 17'sd32767 - p_ext;
        else if (p_ext < pawg_pkg::FOLD_LO)
            fold = -17'sd32768 - p_ext;
        else
            fold = p_ext;
    end

    // Pick the operands of the shared multiplier
    always_comb begin
        case (step_reg)
            pawg_pkg::STEP_X2: begin mul_a = x_reg;             mul_b = x_reg;  end
            pawg_pkg::STEP_X3: begin mul_a = x2_reg;            mul_b = x_reg;  end
            pawg_pkg::STEP_X5: begin mul_a = x2_reg;            mul_b = x3_reg; end
            pawg_pkg::STEP_X7: begin mul_a = x2_reg;            mul_b = x5_reg; end
            pawg_pkg::STEP_T1: begin mul_a = pawg_pkg::COEF_A1; mul_b = x_reg;  end
            pawg_pkg::STEP_T3: begin mul_a = pawg_pkg::COEF_A3; mul_b = x3_reg; end
            pawg_pkg::STEP_T5: begin mul_a = pawg_pkg::COEF_A5; mul_b = x5_reg; end
            pawg_pkg::STEP_T7: begin mul_a = pawg_pkg::COEF_A7; mul_b = x7_reg; end
            default:           begin mul_a = x_reg;             mul_b = x_reg;  end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign qprod = pawg_pkg::qmul_sat(prod);

    // Load the word, then run the power and term steps
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            p_reg    <= q_item.phase;
            last_reg <= q_item.last;
            x_reg    <= fold[W-1:0];
        end
        if (state_reg == pawg_pkg::ST_MUL) begin
            case (step_reg)
                pawg_pkg::STEP_X2: x2_reg  <= qprod;
                pawg_pkg::STEP_X3: x3_reg  <= qprod;
                pawg_pkg::STEP_X5: x5_reg  <= qprod;
                pawg_pkg::STEP_X7: x7_reg  <= qprod;
                pawg_pkg::STEP_T1: acc_reg <= pawg_pkg::ACC_W'(prod);
                default:           acc_reg <= acc_reg + pawg_pkg::ACC_W'(prod);
            endcase
        end
    end

    // Form the sample for the current mode
    assign abs_p = p_reg[W-1] ? W'(-p_reg) : p_reg;
    always_comb begin
        case (mode)
            pawg_pkg::MODE_SAWTOOTH: result = p_reg;
            pawg_pkg::MODE_SQUARE:
                result = (p_reg > threshold) ? pawg_pkg::Q15_MAX : pawg_pkg::Q15_MIN;
            pawg_pkg::MODE_TRIANGLE:
                result = {abs_p[W-2:0], 1'b0} + pawg_pkg::TRI_BIAS;
            pawg_pkg::MODE_SINE:     result = pawg_pkg::poly_out(acc_reg);
            default:                 result = p_reg;
        endcase
    end

    // Hold the finished word until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_sample_reg <= result;
            out_last_reg   <= last_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_sample   = out_sample_reg;
    assign m_last_out = out_last_reg;

endmodule
